[rtl/rars_pkg.sv]
// shared constants and types for the range assign range sum tree
package rars_pkg;

	localparam int MAX_LEAVES_DEF = 65536;
	localparam int VALUE_BITS_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int INDEX_W = 16;
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 32;
	localparam int COUNT_W = 17;

	localparam logic [COUNT_W-1:0] LEAF_COUNT_RST = 17'd65536;

	typedef enum logic [CMD_W-1:0] {
		CMD_REBUILD = 2'd0,
		CMD_ASSIGN  = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_VISIT,
		S_QRD,
		S_PRD,
		S_PUSHL,
		S_PUSHR,
		S_PUSHK,
		S_DESC,
		S_RET,
		S_PULL0,
		S_PULL1,
		S_PULL2,
		S_DONE
	} state_t;

endpackage

[rtl/rars_if.sv]
// channel interfaces: request, response and configuration write
interface rars_req_if;
	logic                        valid;
	logic                        ready;
	logic [rars_pkg::CMD_W-1:0]   cmd;
	logic [rars_pkg::INDEX_W-1:0] left_index;
	logic [rars_pkg::INDEX_W-1:0] right_index;
	logic [rars_pkg::VALUE_W-1:0] assign_value;
	modport source (output valid, cmd, left_index, right_index, assign_value, input ready);
	modport sink (input valid, cmd, left_index, right_index, assign_value, output ready);
endinterface

interface rars_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [rars_pkg::SUM_W-1:0] range_sum;
	logic                      bad_range;
	modport source (output valid, range_sum, bad_range, input ready);
	modport sink (input valid, range_sum, bad_range, output ready);
endinterface

interface rars_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rars_pkg::COUNT_W-1:0] leaf_count;
	modport source (output valid, leaf_count, input ready);
	modport sink (input valid, leaf_count, output ready);
endinterface

[rtl/range_assign_range_sum_tree_top.sv]
// lazy segment tree with range assign and range sum, kept in one node memory
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    cmd, left_index, right_index, assign_value
//  rsp      out  valid/ready    range_sum, bad_range
//  cfg      in   valid/ready    leaf_count
//
// one request at a time; a request is taken only in the idle state
// assign writes each covered node directly; query reads each covered node and adds its
// total; a node passed through is read, its pending tag is pushed to both children when
// set, and after an assign its total is rebuilt from its children; bad or unknown
// requests go straight to the result
// rebuild visits all 2n-1 nodes, writing the leaves and summing each inner node
// arst_n clears control state and sets leaf_count to 65536; the node memory
// holds nothing defined until a rebuild
// a result waits in the output register while the next request is taken
module range_assign_range_sum_tree_top #(
	parameter int MAX_LEAVES = rars_pkg::MAX_LEAVES_DEF,
	parameter int VALUE_BITS = rars_pkg::VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rars_req_if.sink   req,
	rars_rsp_if.source rsp,
	rars_cfg_if.sink   cfg
);

	localparam int IDX_W  = $clog2(MAX_LEAVES);
	localparam int N_W    = IDX_W + 1;
	localparam int ADDR_W = IDX_W + 1;
	localparam int TOT_W  = rars_pkg::SUM_W;
	localparam int WORD_W = TOT_W + VALUE_BITS + 1;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int STK_D  = ADDR_W;
	localparam int STK_IW = $clog2(STK_D);
	localparam int SP_W   = $clog2(STK_D + 1);
	localparam int PROD_W = VALUE_BITS + N_W;

	rars_pkg::state_t state_q, state_d;
	rars_pkg::cmd_t   cmd_q;

	logic [rars_pkg::COUNT_W-1:0] leaf_count_q;
	logic [IDX_W-1:0]      a_q, b_q;
	logic [VALUE_BITS-1:0] v_q, pv_q;
	logic [TOT_W-1:0]      acc_q, ptot_q, ltot_q;
	logic                  bad_q;
	logic [ADDR_W-1:0]     cur_k_q;
	logic [IDX_W-1:0]      cur_lo_q, cur_hi_q;
	logic [SP_W-1:0]       sp_q;

	logic [ADDR_W-1:0] stk_k_q     [STK_D];
	logic [IDX_W-1:0]  stk_lo_q    [STK_D];
	logic [IDX_W-1:0]  stk_hi_q    [STK_D];
	logic              stk_right_q [STK_D];

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;

	logic [TOT_W-1:0] sum_q;
	logic             bad_out_q;
	logic             ovalid_q;

	// request decode
	logic [31:0] l32, r32, lc32, max32, n32;
	logic [31:0] v32, root_hi32;
	logic        in_bad;
	rars_pkg::cmd_t in_cmd;

	assign in_cmd    = rars_pkg::cmd_t'(req.cmd);
	assign l32       = 32'(req.left_index);
	assign r32       = 32'(req.right_index);
	assign v32       = 32'(req.assign_value);
	assign lc32      = 32'(leaf_count_q);
	assign max32     = 32'(MAX_LEAVES);
	assign n32       = (lc32 == 32'd0) ? 32'd1 : ((lc32 > max32) ? max32 : lc32);
	assign root_hi32 = n32 - 32'd1;
	assign in_bad    = (l32 > r32) || (r32 >= n32);

	// current node
	logic [N_W-1:0]    lh_sum, tlh_sum;
	logic [IDX_W-1:0]  mid, t_mid;
	logic [ADDR_W-1:0] k_left, k_right, t_k, t_k_right;
	logic [IDX_W-1:0]  t_lo, t_hi;
	logic              t_right;
	logic [SP_W-1:0]   sp_m1;
	logic [STK_IW-1:0] top_idx, push_idx;
	logic              covered, is_build, top_go_right, node_flag;

	assign lh_sum   = {1'b0, cur_lo_q} + {1'b0, cur_hi_q};
	assign mid      = lh_sum[IDX_W:1];
	assign k_left   = {cur_k_q[ADDR_W-2:0], 1'b0};
	assign k_right  = {cur_k_q[ADDR_W-2:0], 1'b1};
	assign covered  = (a_q <= cur_lo_q) && (b_q >= cur_hi_q);
	assign is_build = (cmd_q == rars_pkg::CMD_REBUILD);
	assign node_flag = rd_q[WORD_W-1];

	assign sp_m1    = sp_q - SP_W'(1);
	assign top_idx  = sp_m1[STK_IW-1:0];
	assign push_idx = sp_q[STK_IW-1:0];
	assign t_k      = stk_k_q[top_idx];
	assign t_lo     = stk_lo_q[top_idx];
	assign t_hi     = stk_hi_q[top_idx];
	assign t_right  = stk_right_q[top_idx];
	assign tlh_sum  = {1'b0, t_lo} + {1'b0, t_hi};
	assign t_mid    = tlh_sum[IDX_W:1];
	assign t_k_right = {t_k[ADDR_W-2:0], 1'b1};
	assign top_go_right = !t_right && (is_build || (b_q > t_mid));

	// shared multiplier for whole-node totals
	logic [VALUE_BITS-1:0] mul_v;
	logic [N_W-1:0]        mul_n;
	logic [PROD_W-1:0]     prod_w;
	logic [TOT_W-1:0]      prod;

	assign prod_w = PROD_W'(mul_v) * PROD_W'(mul_n);
	assign prod   = TOT_W'(prod_w);

	// memory controls
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              done_fire;

	assign done_fire = (state_q == rars_pkg::S_DONE) && (!ovalid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rars_pkg::S_IDLE: begin
				if (req.valid) begin
					if (in_cmd == rars_pkg::CMD_REBUILD)
						state_d = rars_pkg::S_VISIT;
					else if ((in_cmd == rars_pkg::CMD_ASSIGN || in_cmd == rars_pkg::CMD_QUERY) && !in_bad)
						state_d = rars_pkg::S_VISIT;
					else
						state_d = rars_pkg::S_DONE;
				end
			end
			rars_pkg::S_VISIT: begin
				if (is_build)
					state_d = (cur_lo_q == cur_hi_q) ? rars_pkg::S_RET : rars_pkg::S_VISIT;
				else if (covered)
					state_d = (cmd_q == rars_pkg::CMD_ASSIGN) ? rars_pkg::S_RET : rars_pkg::S_QRD;
				else
					state_d = rars_pkg::S_PRD;
			end
			rars_pkg::S_QRD:   state_d = rars_pkg::S_RET;
			rars_pkg::S_PRD:   state_d = node_flag ? rars_pkg::S_PUSHL : rars_pkg::S_DESC;
			rars_pkg::S_PUSHL: state_d = rars_pkg::S_PUSHR;
			rars_pkg::S_PUSHR: state_d = rars_pkg::S_PUSHK;
			rars_pkg::S_PUSHK: state_d = rars_pkg::S_DESC;
			rars_pkg::S_DESC:  state_d = rars_pkg::S_VISIT;
			rars_pkg::S_RET: begin
				if (sp_q == '0)
					state_d = rars_pkg::S_DONE;
				else if (top_go_right)
					state_d = rars_pkg::S_VISIT;
				else if (cmd_q != rars_pkg::CMD_QUERY)
					state_d = rars_pkg::S_PULL0;
				else
					state_d = rars_pkg::S_RET;
			end
			rars_pkg::S_PULL0: state_d = rars_pkg::S_PULL1;
			rars_pkg::S_PULL1: state_d = rars_pkg::S_PULL2;
			rars_pkg::S_PULL2: state_d = rars_pkg::S_RET;
			rars_pkg::S_DONE: begin
				if (done_fire)
					state_d = rars_pkg::S_IDLE;
			end
			default: state_d = rars_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cur_k_q;
		mem_raddr = cur_k_q;
		mem_wdata = {1'b0, pv_q, ptot_q};
		mul_v     = pv_q;
		mul_n     = {1'b0, mid} - {1'b0, cur_lo_q} + N_W'(1);
		unique case (state_q)
			rars_pkg::S_VISIT: begin
				mul_v = v_q;
				mul_n = {1'b0, cur_hi_q} - {1'b0, cur_lo_q} + N_W'(1);
				if (is_build) begin
					if (cur_lo_q == cur_hi_q) begin
						mem_we    = 1'b1;
						mem_wdata = {1'b0, v_q, TOT_W'(1)};
					end
				end else if (covered) begin
					if (cmd_q == rars_pkg::CMD_ASSIGN) begin
						mem_we    = 1'b1;
						mem_wdata = {1'b1, v_q, prod};
					end else begin
						mem_re = 1'b1;
					end
				end else begin
					mem_re = 1'b1;
				end
			end
			rars_pkg::S_PUSHL: begin
				mem_we    = 1'b1;
				mem_waddr = k_left;
				mem_wdata = {1'b1, pv_q, prod};
			end
			rars_pkg::S_PUSHR: begin
				mul_n     = {1'b0, cur_hi_q} - {1'b0, mid};
				mem_we    = 1'b1;
				mem_waddr = k_right;
				mem_wdata = {1'b1, pv_q, prod};
			end
			rars_pkg::S_PUSHK: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b0, pv_q, ptot_q};
			end
			rars_pkg::S_PULL0: begin
				mem_re    = 1'b1;
				mem_raddr = k_left;
			end
			rars_pkg::S_PULL1: begin
				mem_re    = 1'b1;
				mem_raddr = k_right;
			end
			rars_pkg::S_PULL2: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b0, pv_q, ltot_q + rd_q[TOT_W-1:0]};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign req.ready     = (state_q == rars_pkg::S_IDLE);
	assign cfg.ready     = 1'b1;
	assign rsp.valid     = ovalid_q;
	assign rsp.range_sum = sum_q;
	assign rsp.bad_range = bad_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rars_pkg::S_IDLE;
			leaf_count_q <= rars_pkg::LEAF_COUNT_RST;
			ovalid_q     <= 1'b0;
			sp_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid)
				leaf_count_q <= cfg.leaf_count;
			if (done_fire)
				ovalid_q <= 1'b1;
			else if (rsp.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				rars_pkg::S_IDLE: begin
					sp_q <= '0;
				end
				rars_pkg::S_VISIT: begin
					if (is_build && cur_lo_q != cur_hi_q)
						sp_q <= sp_q + SP_W'(1);
				end
				rars_pkg::S_DESC: begin
					sp_q <= sp_q + SP_W'(1);
				end
				rars_pkg::S_RET: begin
					if (sp_q != '0 && !top_go_right)
						sp_q <= sp_m1;
				end
				default: begin
					sp_q <= sp_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			rars_pkg::S_IDLE: begin
				cmd_q    <= in_cmd;
				a_q      <= l32[IDX_W-1:0];
				b_q      <= r32[IDX_W-1:0];
				v_q      <= v32[VALUE_BITS-1:0];
				acc_q    <= '0;
				bad_q    <= (in_cmd == rars_pkg::CMD_ASSIGN || in_cmd == rars_pkg::CMD_QUERY) && in_bad;
				cur_k_q  <= ADDR_W'(1);
				cur_lo_q <= '0;
				cur_hi_q <= root_hi32[IDX_W-1:0];
			end
			rars_pkg::S_VISIT: begin
				if (is_build && cur_lo_q != cur_hi_q) begin
					stk_k_q[push_idx]     <= cur_k_q;
					stk_lo_q[push_idx]    <= cur_lo_q;
					stk_hi_q[push_idx]    <= cur_hi_q;
					stk_right_q[push_idx] <= 1'b0;
					cur_k_q  <= k_left;
					cur_hi_q <= mid;
				end
			end
			rars_pkg::S_QRD: begin
				acc_q <= acc_q + rd_q[TOT_W-1:0];
			end
			rars_pkg::S_PRD: begin
				pv_q   <= rd_q[TOT_W +: VALUE_BITS];
				ptot_q <= rd_q[TOT_W-1:0];
			end
			rars_pkg::S_DESC: begin
				stk_k_q[push_idx]  <= cur_k_q;
				stk_lo_q[push_idx] <= cur_lo_q;
				stk_hi_q[push_idx] <= cur_hi_q;
				if (a_q <= mid) begin
					stk_right_q[push_idx] <= 1'b0;
					cur_k_q  <= k_left;
					cur_hi_q <= mid;
				end else begin
					stk_right_q[push_idx] <= 1'b1;
					cur_k_q  <= k_right;
					cur_lo_q <= mid + IDX_W'(1);
				end
			end
			rars_pkg::S_RET: begin
				if (sp_q != '0) begin
					if (top_go_right) begin
						stk_right_q[top_idx] <= 1'b1;
						cur_k_q  <= t_k_right;
						cur_lo_q <= t_mid + IDX_W'(1);
						cur_hi_q <= t_hi;
					end else begin
						cur_k_q  <= t_k;
						cur_lo_q <= t_lo;
						cur_hi_q <= t_hi;
					end
				end
			end
			rars_pkg::S_PULL1: begin
				ltot_q <= rd_q[TOT_W-1:0];
			end
			rars_pkg::S_DONE: begin
				if (done_fire) begin
					sum_q     <= acc_q;
					bad_out_q <= bad_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// node memory: total, pending value, pending flag
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_raddr];
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STK_D))
		else $error("walk stack overflow");

	a_no_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("read and write of one node in the same cycle");

	a_done_unwound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rars_pkg::S_DONE) |-> (sp_q == '0))
		else $error("result issued with nodes left on the stack");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> ovalid_q && (state_q == rars_pkg::S_IDLE))
		else $error("finished request did not reach the output register");

endmodule
